// ===== src/complex_fir_real_taps_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the complex FIR core checkers.
// Each macro samples on clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_REAL_TAPS_CORE_MACROS_SVH
`define COMPLEX_FIR_REAL_TAPS_CORE_MACROS_SVH

// same-cycle implication
`define CFIR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg
// Constants, codes and helpers for the complex FIR core with real taps.
// ----------------------------------------------------------------------------
package cfir_pkg;

   localparam int MAX_TAPS    = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W       = $clog2(MAX_TAPS + 1);
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int ACC_W       = PROD_W + CNT_W;
   localparam int FRAC_W      = SAMPLE_BITS - 1;

   localparam int TAP_IDX_W   = 6;
   localparam int TAP_COUNT_W = 7;
   localparam int BLOCK_LEN_W = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;
   localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST = 16'd1024;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_TAP    = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_COUNT    = 4'd0,
      CSR_BLOCK_LENGTH = 4'd1
   } cfir_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } cfir_state_type;

   localparam logic signed [ACC_W-1:0] RND_BIAS =
      {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // round half up to Q1.15, then saturate
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] shr;
      sum = acc + RND_BIAS;
      shr = sum >>> FRAC_W;
      if (shr > SAT_MAX) begin
         shr = SAT_MAX;
      end else if (shr < SAT_MIN) begin
         shr = SAT_MIN;
      end
      return shr[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ===== src/cfir_if.sv =====
// ----------------------------------------------------------------------------
// cfir interfaces
// Request, response and register-write channels of the complex FIR core.
// ----------------------------------------------------------------------------
interface cfir_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      action;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]   sample_i;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]   sample_q;
   logic        [cfir_pkg::TAP_IDX_W-1:0]     tap_index;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]   tap_value;

   modport source (
      output valid, action, sample_i, sample_q, tap_index, tap_value,
      input  ready
   );
   modport sink (
      input  valid, action, sample_i, sample_q, tap_index, tap_value,
      output ready
   );
endinterface

interface cfir_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]   out_i;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]   out_q;
   logic                                      block_end;

   modport source (
      output valid, out_i, out_q, block_end,
      input  ready
   );
   modport sink (
      input  valid, out_i, out_q, block_end,
      output ready
   );
endinterface

interface cfir_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cfir_pkg::CSR_IDX_W-1:0]     index;
   logic [cfir_pkg::CSR_DATA_W-1:0]    data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== src/complex_fir_real_taps_core.sv =====
// ----------------------------------------------------------------------------
// complex_fir_real_taps_core
// Block-wise FIR: complex Q1.15 samples against real Q1.15 taps.
// ----------------------------------------------------------------------------
// req_bus carries one beat per item: action 0 filters a sample, action 1
// writes tap_value into tap tap_index (no response beat).
// rsp_bus returns one beat per sample: rounded, saturated out_i/out_q and
// block_end, set on the last sample of a block (history cleared after it).
// csr_bus writes tap_count (index 0) and block_length (index 1); always ready.
// A tap write completes in the idle state, with req ready staying high. From
// accepting a sample to its response beat req ready is low; the single
// complex-by-real MAC walks the taps one per cycle from the history and tap
// memories.
// The response sits in an output register; a new item can be accepted while
// it waits, but the next sample holds in its final step until the receiver
// takes the pending beat.
// Reset clears taps and history (per-entry valid bits), block position and the
// output valid flag; tap_count returns to 1 and block_length to 1024.
// ----------------------------------------------------------------------------
module complex_fir_real_taps_core (
   input  logic        clock,
   input  logic        reset,
   cfir_req_if.sink    req_bus,
   cfir_rsp_if.source  rsp_bus,
   cfir_csr_if.sink    csr_bus
);

   cfir_pkg::cfir_state_type                     state_ff, state_in;
   logic [cfir_pkg::CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [cfir_pkg::CNT_W-1:0]                   ntap_ff, ntap_in;
   logic [cfir_pkg::CNT_W-1:0]                   ntap_sel;
   logic [cfir_pkg::ADDR_W-1:0]                  wp_ff, wp_in;
   logic [cfir_pkg::BLOCK_LEN_W-1:0]             pos_ff, pos_in, pos_step;
   logic [cfir_pkg::MAX_TAPS-1:0]                dvld_ff, dvld_in;
   logic [cfir_pkg::MAX_TAPS-1:0]                tvld_ff, tvld_in;
   logic [cfir_pkg::TAP_COUNT_W-1:0]             tap_count_ff;
   logic [cfir_pkg::BLOCK_LEN_W-1:0]             block_length_ff;

   logic                                         rd_vld_ff, prod_vld_ff;
   logic                                         rsp_valid_ff, rsp_valid_in;
   logic                                         issue, fin_go, blk_last;
   logic                                         dmem_we, tmem_we, tap_ok;
   logic [cfir_pkg::ADDR_W-1:0]                  tap_addr, k_addr, d_addr;

   logic [cfir_pkg::PROD_W-1:0]                  dmem [cfir_pkg::MAX_TAPS];
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]      tmem [cfir_pkg::MAX_TAPS];

   logic [cfir_pkg::PROD_W-1:0]                  rd_d_ff;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]      rd_t_ff;
   logic                                         rd_dv_ff, rd_tv_ff;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]      mul_i, mul_q, mul_t;
   logic signed [cfir_pkg::PROD_W-1:0]           prod_i_ff, prod_q_ff;
   logic signed [cfir_pkg::ACC_W-1:0]            acc_i_ff, acc_q_ff;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0]      out_i_ff, out_q_ff;
   logic                                         block_end_ff;

   assign ntap_sel = (int'(tap_count_ff) > cfir_pkg::MAX_TAPS)
                   ? cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS)
                   : cfir_pkg::CNT_W'(tap_count_ff);
   assign tap_ok   = int'(req_bus.tap_index) < cfir_pkg::MAX_TAPS;
   assign tap_addr = cfir_pkg::ADDR_W'(req_bus.tap_index);
   assign k_addr   = cnt_ff[cfir_pkg::ADDR_W-1:0];
   // history lag k lives at wp - k, modulo the line depth
   assign d_addr   = (wp_ff >= k_addr) ? (wp_ff - k_addr)
                   : (cfir_pkg::ADDR_W'(cfir_pkg::MAX_TAPS) + wp_ff - k_addr);
   assign pos_step = pos_ff + 1'b1;
   assign blk_last = (pos_step == block_length_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ntap_in      = ntap_ff;
      wp_in        = wp_ff;
      pos_in       = pos_ff;
      dvld_in      = dvld_ff;
      tvld_in      = tvld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      req_bus.ready = 1'b0;
      issue        = 1'b0;
      fin_go       = 1'b0;
      dmem_we      = 1'b0;
      tmem_we      = 1'b0;
      unique case (state_ff)
         cfir_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.action == cfir_pkg::ACT_TAP) begin
                  if (tap_ok) begin
                     tmem_we           = 1'b1;
                     tvld_in[tap_addr] = 1'b1;
                  end
               end else begin
                  dmem_we        = 1'b1;
                  dvld_in[wp_ff] = 1'b1;
                  cnt_in         = '0;
                  ntap_in        = ntap_sel;
                  state_in       = cfir_pkg::ST_RUN;
               end
            end
         end
         cfir_pkg::ST_RUN: begin
            if (cnt_ff < ntap_ff) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = cfir_pkg::ST_FIN;
            end
         end
         cfir_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               fin_go       = 1'b1;
               rsp_valid_in = 1'b1;
               wp_in        = (wp_ff == cfir_pkg::ADDR_W'(cfir_pkg::MAX_TAPS - 1))
                            ? '0 : (wp_ff + 1'b1);
               pos_in       = blk_last ? '0 : pos_step;
               if (blk_last) begin
                  dvld_in = '0;
               end
               state_in     = cfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfir_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cfir_pkg::ST_IDLE;
         cnt_ff          <= '0;
         ntap_ff         <= '0;
         wp_ff           <= '0;
         pos_ff          <= '0;
         dvld_ff         <= '0;
         tvld_ff         <= '0;
         rd_vld_ff       <= 1'b0;
         prod_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         tap_count_ff    <= cfir_pkg::TAP_COUNT_RST;
         block_length_ff <= cfir_pkg::BLOCK_LEN_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ntap_ff      <= ntap_in;
         wp_ff        <= wp_in;
         pos_ff       <= pos_in;
         dvld_ff      <= dvld_in;
         tvld_ff      <= tvld_in;
         rd_vld_ff    <= issue;
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            if (csr_bus.index == cfir_pkg::CSR_TAP_COUNT) begin
               tap_count_ff <= csr_bus.data[cfir_pkg::TAP_COUNT_W-1:0];
            end else if (csr_bus.index == cfir_pkg::CSR_BLOCK_LENGTH) begin
               block_length_ff <= csr_bus.data[cfir_pkg::BLOCK_LEN_W-1:0];
            end
         end
      end
   end

   assign csr_bus.ready = 1'b1;

   // history and tap memories, registered reads
   always_ff @(posedge clock) begin
      if (dmem_we) begin
         dmem[wp_ff] <= {req_bus.sample_i, req_bus.sample_q};
      end
      if (tmem_we) begin
         tmem[tap_addr] <= req_bus.tap_value;
      end
      rd_d_ff  <= dmem[d_addr];
      rd_t_ff  <= tmem[k_addr];
      rd_dv_ff <= dvld_ff[d_addr];
      rd_tv_ff <= tvld_ff[k_addr];
   end

   assign mul_i = rd_dv_ff ? signed'(rd_d_ff[cfir_pkg::PROD_W-1:cfir_pkg::SAMPLE_BITS]) : '0;
   assign mul_q = rd_dv_ff ? signed'(rd_d_ff[cfir_pkg::SAMPLE_BITS-1:0]) : '0;
   assign mul_t = rd_tv_ff ? rd_t_ff : '0;

   always_ff @(posedge clock) begin
      prod_i_ff <= mul_i * mul_t;
      prod_q_ff <= mul_q * mul_t;
      if (dmem_we) begin
         acc_i_ff <= '0;
         acc_q_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_i_ff <= acc_i_ff + cfir_pkg::ACC_W'(prod_i_ff);
         acc_q_ff <= acc_q_ff + cfir_pkg::ACC_W'(prod_q_ff);
      end
      if (fin_go) begin
         out_i_ff     <= cfir_pkg::round_sat(acc_i_ff);
         out_q_ff     <= cfir_pkg::round_sat(acc_q_ff);
         block_end_ff <= blk_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_i     = out_i_ff;
   assign rsp_bus.out_q     = out_q_ff;
   assign rsp_bus.block_end = block_end_ff;

endmodule

// ===== src/cfir_checker.sv =====
// ----------------------------------------------------------------------------
// cfir_checker
// Port-level checks of the complex FIR core, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_fir_real_taps_core_macros.svh"

module cfir_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    req_action,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [cfir_pkg::SAMPLE_BITS-1:0] rsp_out_i,
   input logic signed [cfir_pkg::SAMPLE_BITS-1:0] rsp_out_q,
   input logic                                    rsp_block_end
);

   logic smp_beat, tap_beat;

   assign smp_beat = req_valid && req_ready && (req_action == cfir_pkg::ACT_SAMPLE);
   assign tap_beat = req_valid && req_ready && (req_action == cfir_pkg::ACT_TAP);

   `CFIR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_i) && $stable(rsp_out_q) && $stable(rsp_block_end),
      "stalled response beat changed")
   `CFIR_ASSERT_NEXT(a_busy_after_sample, smp_beat, !req_ready,
      "request ready right after a sample beat")
   `CFIR_ASSERT_NEXT(a_ready_after_tap, tap_beat, req_ready,
      "request ready dropped after a tap write")
   `CFIR_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(!req_ready),
      "response beat appeared without a sample in progress")

endmodule

bind complex_fir_real_taps_core cfir_checker u_cfir_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_action    (req_bus.action),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_i     (rsp_bus.out_i),
   .rsp_out_q     (rsp_bus.out_q),
   .rsp_block_end (rsp_bus.block_end)
);
